/* src/sdtc_pkg.sv */
// Shared types, codes and helpers for the static dictionary text compressor.
`timescale 1ns / 1ps
package sdtc_pkg;

    localparam int ONE_CHAR_START_D   = 3;
    localparam int TWO_CHAR_START_D   = 96;
    localparam int THREE_CHAR_START_D = 176;
    localparam int MAX_LITERAL_D      = 32;
    localparam int MAX_RESULTS        = 64;
    localparam int BUDGET_RESET       = 255;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEXT = 1'b1;

    localparam logic [7:0] MARK_END = 8'd0;
    localparam logic [7:0] MARK_RUN = 8'd1;
    localparam logic [7:0] MARK_ONE = 8'd2;

    // search outcome codes besides real dictionary codes
    localparam logic [7:0] CODE_EOS  = 8'd0;
    localparam logic [7:0] CODE_NONE = 8'd1;

    typedef struct packed {
        logic        operation;
        logic [7:0]  entry_code;
        logic [23:0] entry_text;
        logic [7:0]  text_byte;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECIDE, ST_SCAN, ST_PICK, ST_EVAL, ST_HDR, ST_CNT,
        ST_DATA, ST_POST, ST_CODE, ST_END, ST_DONE
    } state_t;

    function automatic logic [1:0] code_len(input logic [7:0] c, input int one,
                                            input int two, input int three);
        if (int'(c) >= three) return 2'd3;
        if (int'(c) >= two) return 2'd2;
        if (int'(c) >= one) return 2'd1;
        return 2'd0;
    endfunction

    function automatic logic [23:0] len_mask(input logic [1:0] n);
        case (n)
            2'd3:    return 24'hFFFFFF;
            2'd2:    return 24'h00FFFF;
            default: return 24'h0000FF;
        endcase
    endfunction

endpackage

/* src/static_dictionary_text_compressor.sv */
// Top level of the static dictionary text compressor.
// Load words and text bytes that do not complete the three-byte lookahead
// window are taken while the engine is idle. Each greedy decision with bytes
// in the window and budget left scans the dictionary memory one entry per
// cycle, from the top code down to ONE_CHAR_START. Flushing a literal run
// emits a marker, a count for runs longer than one byte and the run's bytes,
// then passes through a post state. A word that starts a decision waits in a
// done state until its last result can move to the output register. A zero
// byte repeats decisions until the window drains. A two-word input queue lets
// words arrive during a scan, and results leave through an output register
// backed by a one-word staging stage.
`timescale 1ns / 1ps
module static_dictionary_text_compressor import sdtc_pkg::*; #(
    parameter int ONE_CHAR_START   = ONE_CHAR_START_D,
    parameter int TWO_CHAR_START   = TWO_CHAR_START_D,
    parameter int THREE_CHAR_START = THREE_CHAR_START_D,
    parameter int MAX_LITERAL      = MAX_LITERAL_D
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // entry_code, entry_text, text_byte
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast,   // run_last
    output logic        m_tuser,   // string_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic       budget_we;
    logic [7:0] budget_reg;
    logic       q_valid, q_pop;
    item_t      q_item;

    assign cfg_ready = 1'b1;
    assign budget_we = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg <= 8'(BUDGET_RESET);
        end else if (budget_we) begin
            budget_reg <= cfg_data;
        end
    end

    sdtc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    sdtc_back #(
        .ONE_CHAR_START   (ONE_CHAR_START),
        .TWO_CHAR_START   (TWO_CHAR_START),
        .THREE_CHAR_START (THREE_CHAR_START),
        .MAX_LITERAL      (MAX_LITERAL)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .budget   (budget_we ? cfg_data : budget_reg),
        .cfg_we   (budget_we),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* src/sdtc_front.sv */
// Input side: accepts words, unpacks them and queues them for the engine.
`timescale 1ns / 1ps
module sdtc_front import sdtc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push;
    item_t       in_item;

    assign in_item.operation  = s_tuser;
    assign in_item.entry_code = s_tdata[7:0];
    assign in_item.entry_text = s_tdata[31:8];
    assign in_item.text_byte  = s_tdata[39:32];

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop && q_valid) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end

endmodule

/* src/sdtc_back.sv */
// Engine: dictionary store and scan, lookahead window, literal runs, output stage.
`timescale 1ns / 1ps
module sdtc_back import sdtc_pkg::*; #(
    parameter int ONE_CHAR_START   = ONE_CHAR_START_D,
    parameter int TWO_CHAR_START   = TWO_CHAR_START_D,
    parameter int THREE_CHAR_START = THREE_CHAR_START_D,
    parameter int MAX_LITERAL      = MAX_LITERAL_D
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  item_t      q_item,
    output logic       q_pop,
    input  logic [7:0] budget,
    input  logic       cfg_we,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser
);

    localparam int DICT_DEPTH = 256 - ONE_CHAR_START;
    localparam int DAW        = $clog2(DICT_DEPTH);
    localparam int LW         = $clog2(MAX_LITERAL + 1);
    localparam int IW         = $clog2(MAX_LITERAL);

    logic [23:0] dict_mem [DICT_DEPTH];
    logic [7:0]  lit_mem  [MAX_LITERAL];
    logic [23:0] dict_rd_reg;
    logic [7:0]  lit_rd_reg;

    state_t      state_reg, state_next;
    logic        loop_reg, loop_next;
    logic [23:0] win_reg, win_next;
    logic [1:0]  fill_reg, fill_next;
    logic [LW-1:0] lit_len_reg, lit_len_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [7:0]  left_reg, left_next;
    logic        fin_reg, fin_next;
    logic [7:0]  scan_reg, scan_next;
    logic        f1_reg, f2_reg, f3_reg, f1_next, f2_next, f3_next;
    logic [7:0]  c1_reg, c2_reg, c3_reg, c1_next, c2_next, c3_next;
    logic [7:0]  code_reg, code_next;
    logic [6:0]  rcnt_reg;

    logic        stg_valid_reg, stg_end_reg;
    logic [7:0]  stg_byte_reg;
    logic        out_valid_reg, out_last_reg, out_end_reg;
    logic [7:0]  out_byte_reg;

    logic        out_free, emit_ok, emit_en, emit_end, keep, move_emit, move_done;
    logic [7:0]  emit_byte;
    logic        dict_we, lit_we;
    logic [7:0]  dict_wcode, scan_off, wr_off;
    logic [IW-1:0] lit_wa;
    logic [1:0]  ln, item_len;
    logic        hit;
    logic [8:0]  lit9;
    logic [2:0]  fill_add;

    assign out_free = !out_valid_reg || m_tready;
    assign emit_ok  = !stg_valid_reg || out_free;
    assign lit9     = {{(9-LW){1'b0}}, lit_len_reg};

    assign ln   = code_len(scan_reg, ONE_CHAR_START, TWO_CHAR_START, THREE_CHAR_START);
    assign hit  = (dict_rd_reg == (win_reg & len_mask(ln)));
    assign item_len = code_len(q_item.entry_code, ONE_CHAR_START, TWO_CHAR_START,
                               THREE_CHAR_START);
    assign dict_wcode = q_item.entry_code;
    assign scan_off   = scan_next - 8'(ONE_CHAR_START);
    assign wr_off     = dict_wcode - 8'(ONE_CHAR_START);

    always_ff @(posedge aclk) begin
        if (dict_we) dict_mem[wr_off[DAW-1:0]] <= q_item.entry_text & len_mask(item_len);
        dict_rd_reg <= dict_mem[scan_off[DAW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (lit_we) lit_mem[lit_wa] <= win_reg[7:0];
        lit_rd_reg <= lit_mem[idx_next[IW-1:0]];
    end

    always_comb begin
        state_next   = state_reg;
        loop_next    = loop_reg;
        win_next     = win_reg;
        fill_next    = fill_reg;
        lit_len_next = lit_len_reg;
        idx_next     = idx_reg;
        left_next    = left_reg;
        fin_next     = fin_reg;
        scan_next    = scan_reg - 8'd1;
        f1_next = f1_reg; f2_next = f2_reg; f3_next = f3_reg;
        c1_next = c1_reg; c2_next = c2_reg; c3_next = c3_reg;
        code_next    = code_reg;
        emit_en      = 1'b0;
        emit_byte    = MARK_END;
        emit_end     = 1'b0;
        q_pop        = 1'b0;
        dict_we      = 1'b0;
        lit_we       = 1'b0;
        lit_wa       = lit_len_reg[IW-1:0];
        fill_add     = 3'd0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_item.operation == OP_LOAD) begin
                        dict_we = (item_len != 2'd0);
                    end else if (fin_reg || left_reg == 8'd0) begin
                        if (q_item.text_byte == 8'd0) begin
                            win_next = '0; fill_next = '0; lit_len_next = '0;
                            fin_next = 1'b0; left_next = budget;
                        end
                    end else if (q_item.text_byte != 8'd0) begin
                        fill_add = {1'b0, fill_reg};
                        if (fill_reg != 2'd3) begin
                            case (fill_reg)
                                2'd0:    win_next = win_reg | {16'd0, q_item.text_byte};
                                2'd1:    win_next = win_reg | {8'd0, q_item.text_byte, 8'd0};
                                default: win_next = win_reg | {q_item.text_byte, 16'd0};
                            endcase
                            fill_add = {1'b0, fill_reg} + 3'd1;
                            fill_next = fill_add[1:0];
                        end
                        if (fill_add == 3'd3) begin
                            loop_next  = 1'b0;
                            state_next = ST_DECIDE;
                        end
                    end else begin
                        loop_next  = 1'b1;
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                if (left_reg <= 8'd1) begin
                    state_next = ST_END;
                end else if (fill_reg == 2'd0) begin
                    code_next  = CODE_EOS;
                    state_next = ST_EVAL;
                end else begin
                    scan_next  = 8'd255;
                    f1_next = 1'b0; f2_next = 1'b0; f3_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    case (ln)
                        2'd3: if (!f3_reg) begin f3_next = 1'b1; c3_next = scan_reg; end
                        2'd2: if (!f2_reg) begin f2_next = 1'b1; c2_next = scan_reg; end
                        2'd1: if (!f1_reg) begin f1_next = 1'b1; c1_next = scan_reg; end
                        default: ;
                    endcase
                end
                if (scan_reg == 8'(ONE_CHAR_START)) state_next = ST_PICK;
            end
            ST_PICK: begin
                if (f3_reg && fill_reg == 2'd3)      code_next = c3_reg;
                else if (f2_reg && fill_reg >= 2'd2) code_next = c2_reg;
                else if (f1_reg)                     code_next = c1_reg;
                else                                 code_next = CODE_NONE;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (lit_len_reg == '0) begin
                    state_next = ST_CODE;
                end else if (code_reg == CODE_NONE && lit9 < 9'(MAX_LITERAL) &&
                             {1'b0, left_reg} >= lit9 + 9'd4) begin
                    lit_we       = 1'b1;
                    lit_len_next = lit_len_reg + 1'b1;
                    win_next     = win_reg >> 8;
                    fill_next    = fill_reg - 2'd1;
                    state_next   = loop_reg ? ST_DECIDE : ST_DONE;
                end else if ({1'b0, left_reg} <
                             ((lit9 > 9'd1) ? lit9 + 9'd3 : 9'd3)) begin
                    lit_len_next = '0;
                    state_next   = ST_END;
                end else begin
                    idx_next   = '0;
                    state_next = ST_HDR;
                end
            end
            ST_HDR: begin
                if (emit_ok) begin
                    emit_en    = 1'b1;
                    emit_byte  = (lit_len_reg > LW'(1)) ? MARK_RUN : MARK_ONE;
                    state_next = (lit_len_reg > LW'(1)) ? ST_CNT : ST_DATA;
                end
            end
            ST_CNT: begin
                if (emit_ok) begin
                    emit_en    = 1'b1;
                    emit_byte  = {{(8-LW){1'b0}}, lit_len_reg};
                    state_next = ST_DATA;
                end
            end
            ST_DATA: begin
                if (emit_ok) begin
                    emit_en   = 1'b1;
                    emit_byte = lit_rd_reg;
                    if (LW'(idx_reg + 1'b1) == lit_len_reg) begin
                        lit_len_next = '0;
                        state_next   = ST_POST;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_POST: begin
                state_next = (left_reg <= 8'd1) ? ST_END : ST_CODE;
            end
            ST_CODE: begin
                if (int'(code_reg) >= ONE_CHAR_START) begin
                    if (emit_ok) begin
                        emit_en   = 1'b1;
                        emit_byte = code_reg;
                        case (code_len(code_reg, ONE_CHAR_START, TWO_CHAR_START,
                                       THREE_CHAR_START))
                            2'd3: begin win_next = '0; fill_next = fill_reg - 2'd3; end
                            2'd2: begin win_next = win_reg >> 16; fill_next = fill_reg - 2'd2; end
                            default: begin win_next = win_reg >> 8; fill_next = fill_reg - 2'd1; end
                        endcase
                        state_next = loop_reg ? ST_DECIDE : ST_DONE;
                    end
                end else if (code_reg == CODE_NONE) begin
                    lit_we       = 1'b1;
                    lit_wa       = '0;
                    lit_len_next = LW'(1);
                    win_next     = win_reg >> 8;
                    fill_next    = fill_reg - 2'd1;
                    state_next   = loop_reg ? ST_DECIDE : ST_DONE;
                end else begin
                    state_next = ST_END;
                end
            end
            ST_END: begin
                if (emit_ok) begin
                    emit_en   = 1'b1;
                    emit_byte = MARK_END;
                    emit_end  = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!stg_valid_reg || out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        if (emit_en && left_reg != 8'd0) left_next = left_reg - 8'd1;
        if (state_reg == ST_END && emit_en) begin
            if (loop_reg) begin
                win_next = '0; fill_next = '0; lit_len_next = '0;
                fin_next = 1'b0; left_next = budget;
            end else begin
                fin_next = 1'b1;
            end
        end
    end

    assign keep      = emit_en && (rcnt_reg < 7'(MAX_RESULTS));
    assign move_emit = keep && stg_valid_reg;
    assign move_done = (state_reg == ST_DONE) && stg_valid_reg && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            loop_reg    <= 1'b0;
            win_reg     <= '0;
            fill_reg    <= '0;
            lit_len_reg <= '0;
            idx_reg     <= '0;
            left_reg    <= 8'(BUDGET_RESET);
            fin_reg     <= 1'b0;
            rcnt_reg    <= '0;
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            loop_reg    <= loop_next;
            win_reg     <= win_next;
            fill_reg    <= fill_next;
            lit_len_reg <= lit_len_next;
            idx_reg     <= idx_next;
            left_reg    <= cfg_we ? budget : left_next;
            fin_reg     <= fin_next;
            if (q_pop) rcnt_reg <= '0;
            else if (keep) rcnt_reg <= rcnt_reg + 7'd1;
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            if (move_emit || move_done) out_valid_reg <= 1'b1;
            if (keep) stg_valid_reg <= 1'b1;
            else if (move_done) stg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
        f1_reg <= f1_next; f2_reg <= f2_next; f3_reg <= f3_next;
        c1_reg <= c1_next; c2_reg <= c2_next; c3_reg <= c3_next;
        code_reg <= code_next;
        if (keep) begin
            stg_byte_reg <= emit_byte;
            stg_end_reg  <= emit_end;
        end
        if (move_emit || move_done) begin
            out_byte_reg <= stg_byte_reg;
            out_end_reg  <= stg_end_reg;
            out_last_reg <= move_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_end_reg;

endmodule
